/* sv/esc_pwm_pkg.sv */
// Shared types and constants for the multi-channel ESC PWM generator.
`timescale 1ns / 1ps
`default_nettype none

package esc_pwm_pkg;

  // Default sizing
  localparam int CHANNELS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;

  // Register reset values
  localparam logic [15:0] PERIOD_RST    = 16'd52500;
  localparam logic [15:0] MIN_COUNT_RST = 16'd23100;
  localparam logic [7:0]  STEP_RST      = 8'd65;

  // Request function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Number of pins visible in a result
  localparam int PIN_BITS = 8;

  // Input request payload
  typedef struct packed {
    logic              func;
    logic [7:0]        channel;
    logic signed [7:0] throttle;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic [PIN_BITS-1:0] pin_levels;
    logic                index_error;
  } out_rsp_t;

  // Decoded request control, input stage to core
  typedef struct packed {
    logic is_set;
    logic chan_ok;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/esc_pwm_decode.sv */
// Input stage: registers a request with its channel check and computed pulse width.
`timescale 1ns / 1ps
`default_nettype none

module esc_pwm_decode #(
  parameter int CHANNELS   = esc_pwm_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = esc_pwm_pkg::COUNT_BITS_DEF,
  parameter int ChIdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire esc_pwm_pkg::in_req_t   in_req_i,
  input  wire logic [15:0]            min_count_i,
  input  wire logic [7:0]             step_i,
  input  wire logic                   adv_i,
  output logic                        valid_o,
  output esc_pwm_pkg::cmd_t           cmd_o,
  output logic [ChIdxW-1:0]           idx_o,
  output logic [COUNT_BITS-1:0]       width_o
);
  import esc_pwm_pkg::*;

  localparam int SumW = (COUNT_BITS > 17) ? COUNT_BITS : 17;

  logic                  valid_q, valid_d;
  cmd_t                  cmd_q, cmd_d;
  logic [ChIdxW-1:0]     idx_q;
  logic [COUNT_BITS-1:0] width_q, width_d;
  logic                  load;
  logic [7:0]            level;
  logic [15:0]           prod;
  logic [SumW-1:0]       sum_w;
  logic                  sat;

  // Stage is free when empty or draining this cycle
  assign in_stall_o = valid_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;

  // Throttle offset by 128 to an unsigned level
  assign level = {~in_req_i.throttle[7], in_req_i.throttle[6:0]};
  assign prod  = 16'(step_i) * 16'(level);
  assign sum_w = SumW'(min_count_i) + SumW'(prod);

  // Saturate at the counter range
  assign sat     = (sum_w >> COUNT_BITS) != '0;
  assign width_d = sat ? '1 : sum_w[COUNT_BITS-1:0];

  assign cmd_d.is_set  = (in_req_i.func == FUNC_SET);
  assign cmd_d.chan_ok = (in_req_i.channel < 8'(CHANNELS));

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q   <= cmd_d;
      idx_q   <= in_req_i.channel[ChIdxW-1:0];
      width_q <= width_d;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign idx_o   = idx_q;
  assign width_o = width_q;

endmodule

`default_nettype wire

/* sv/esc_pwm_core.sv */
// PWM core: shared counter, pending and active widths, pin compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module esc_pwm_core #(
  parameter int CHANNELS   = esc_pwm_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = esc_pwm_pkg::COUNT_BITS_DEF,
  parameter int ChIdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [15:0]            period_i,
  input  wire logic                   valid_i,
  input  wire esc_pwm_pkg::cmd_t      cmd_i,
  input  wire logic [ChIdxW-1:0]      idx_i,
  input  wire logic [COUNT_BITS-1:0]  width_i,
  output logic                        adv_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output esc_pwm_pkg::out_rsp_t       out_rsp_o
);
  import esc_pwm_pkg::*;

  localparam int CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [COUNT_BITS-1:0] active_q  [CHANNELS];
  logic [COUNT_BITS-1:0] active_d  [CHANNELS];
  logic [COUNT_BITS-1:0] pending_q [CHANNELS];
  logic [COUNT_BITS-1:0] pending_d [CHANNELS];
  logic                  wrap;
  logic                  out_valid_q, out_valid_d;
  out_rsp_t              rsp_q, rsp_d;
  logic [PIN_BITS-1:0]   levels;

  // Take the held request when the result register is free
  assign adv_o = valid_i && (!out_valid_q || !out_stall_i);

  assign wrap = CmpW'(tick_q) >= CmpW'(period_i);

  // Counter and width updates
  always_comb begin
    tick_d    = tick_q;
    active_d  = active_q;
    pending_d = pending_q;
    if (adv_o) begin
      if (!cmd_i.is_set) begin
        if (wrap) begin
          tick_d   = '0;
          active_d = pending_q;
        end else begin
          tick_d = tick_q + COUNT_BITS'(1);
        end
      end else if (cmd_i.chan_ok) begin
        pending_d[idx_i] = width_i;
      end
    end
  end

  // Pin compare against the updated state
  for (genvar n = 0; n < PIN_BITS; n++) begin : g_pin
    if (n < CHANNELS) begin : g_used
      assign levels[n] = tick_d < active_d[n];
    end else begin : g_unused
      assign levels[n] = 1'b0;
    end
  end

  assign rsp_d.pin_levels  = levels;
  assign rsp_d.index_error = cmd_i.is_set && !cmd_i.chan_ok;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        active_q[i]  <= '0;
        pending_q[i] <= '0;
      end
    end else begin
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      pending_q   <= pending_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

/* sv/multi_channel_esc_pwm.sv */
// Top level of the multi-channel ESC PWM generator with its configuration registers.
//
//   Channel  Direction  Handshake                Payload
//   in       request    in_valid_i / in_stall_o  in_req_i   (func, channel, throttle)
//   out      result     out_valid_o / out_stall_i out_rsp_o (pin_levels, index_error)
//   cfg      write      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Each request produces one result: it is registered first in the input register (channel
// check, width multiply-add), then in the counter/compare stage.
// A new request can be accepted every cycle while the output does not stall.
// Reset clears the counter and all widths, so every pin starts low.
// A stalled output holds its result; the input register stalls only when both stages hold.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_esc_pwm #(
  parameter int CHANNELS   = esc_pwm_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = esc_pwm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire esc_pwm_pkg::in_req_t                in_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output esc_pwm_pkg::out_rsp_t                    out_rsp_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [esc_pwm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [esc_pwm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import esc_pwm_pkg::*;

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0]           period_q;
  logic [15:0]           min_count_q;
  logic [7:0]            step_q;
  logic                  adv;
  logic                  s1_valid;
  cmd_t                  s1_cmd;
  logic [ChIdxW-1:0]     s1_idx;
  logic [COUNT_BITS-1:0] s1_width;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      min_count_q <= MIN_COUNT_RST;
      step_q      <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD:    period_q    <= cfg_wdata_i[15:0];
        CFG_MIN_COUNT: min_count_q <= cfg_wdata_i[15:0];
        CFG_STEP:      step_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  esc_pwm_decode #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS),
    .ChIdxW     (ChIdxW)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .min_count_i (min_count_q),
    .step_i      (step_q),
    .adv_i       (adv),
    .valid_o     (s1_valid),
    .cmd_o       (s1_cmd),
    .idx_o       (s1_idx),
    .width_o     (s1_width)
  );

  esc_pwm_core #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS),
    .ChIdxW     (ChIdxW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .valid_i     (s1_valid),
    .cmd_i       (s1_cmd),
    .idx_i       (s1_idx),
    .width_i     (s1_width),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
